// ===== rtl/lpfd_pkg.sv =====
// ----------------------------------------------------------------------------
// lpfd_pkg
// Shared types and constants of the length-prefixed frame deframer.
// ----------------------------------------------------------------------------
package lpfd_pkg;

	localparam logic [31:0] MAX_FRAME_LEN_RST = 32'(512 * 1024 - 4);
	localparam logic [7:0]  CH_CR             = 8'h0D;
	localparam logic [7:0]  CH_LF             = 8'h0A;
	localparam logic [7:0]  BYTE_ZERO         = 8'h00;
	localparam logic [2:0]  WIN_BYTES         = 3'd4;

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_PREFIX  = 2'd1,
		PH_PAYLOAD = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		EV_PAYLOAD = 2'd0,
		EV_BAD_LEN = 2'd1,
		EV_HDR_END = 2'd2
	} event_t;

	typedef struct packed {
		event_t      event_res;
		logic [7:0]  payload_byte;
		logic        last_of_frame;
		logic [31:0] frame_length;
	} result_t;

	// handshake between the stages
	typedef struct packed {
		logic valid;
		logic advance;
	} stage_ctl_t;

endpackage

// ===== rtl/lpfd_in_reg.sv =====
// ----------------------------------------------------------------------------
// lpfd_in_reg
// Input register: holds one stream byte until the core consumes it.
// ----------------------------------------------------------------------------
module lpfd_in_reg (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data,
	input  logic       advance,
	output logic       valid_s1,
	output logic [7:0] data_s1
);
	import lpfd_pkg::*;

	logic load;

	// stall only while a held word cannot move on
	assign in_stall = valid_s1 && !advance;
	assign load     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_s1 <= data;
		end
	end

endmodule

// ===== rtl/lpfd_core.sv =====
// ----------------------------------------------------------------------------
// lpfd_core
// Deframer state: header search, prefix window, payload count.
// Computes the result of the held word and advances state when it moves on.
// ----------------------------------------------------------------------------
module lpfd_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [7:0]       data_s1,
	input  lpfd_pkg::stage_ctl_t ctl,
	input  logic [31:0]      max_frame_len,
	output logic             res_valid,
	output lpfd_pkg::result_t res
);
	import lpfd_pkg::*;

	phase_t      phase_q,   phase_d;
	logic [1:0]  hmatch_q,  hmatch_d;
	logic [31:0] win_q,     win_d;
	logic [2:0]  fill_q,    fill_d;
	logic [31:0] remain_q,  remain_d;
	logic [31:0] cur_len_q, cur_len_d;

	logic [31:0] win_shift;
	logic [2:0]  fill_inc;
	logic        win_full;
	logic        len_bad;
	logic [31:0] remain_dec;
	logic        pay_last;
	logic        hdr_end;

	assign win_shift  = {win_q[23:0], data_s1};
	assign fill_inc   = (fill_q < WIN_BYTES) ? fill_q + 3'd1 : fill_q;
	assign win_full   = (fill_inc >= WIN_BYTES);
	assign len_bad    = (win_shift == 32'd0) || (win_shift > max_frame_len);
	assign remain_dec = (remain_q != 32'd0) ? remain_q - 32'd1 : 32'd0;
	assign pay_last   = (remain_dec == 32'd0);
	assign hdr_end    = (hmatch_q == 2'd3) && (data_s1 == CH_LF);

	// next state
	always_comb begin
		phase_d   = phase_q;
		hmatch_d  = hmatch_q;
		win_d     = win_q;
		fill_d    = fill_q;
		remain_d  = remain_q;
		cur_len_d = cur_len_q;
		unique case (phase_q)
			PH_HEADER: begin
				if (hdr_end) begin
					hmatch_d = 2'd0;
					phase_d  = PH_PREFIX;
					fill_d   = 3'd0;
					win_d    = 32'd0;
				end else begin
					unique case (hmatch_q)
						2'd1: hmatch_d = (data_s1 == CH_LF) ? 2'd2 :
						                 ((data_s1 == CH_CR) ? 2'd1 : 2'd0);
						2'd2: hmatch_d = (data_s1 == CH_CR) ? 2'd3 : 2'd0;
						default: hmatch_d = (data_s1 == CH_CR) ? 2'd1 : 2'd0;
					endcase
				end
			end
			PH_PAYLOAD: begin
				remain_d = remain_dec;
				if (pay_last) begin
					phase_d = PH_PREFIX;
					fill_d  = 3'd0;
					win_d   = 32'd0;
				end
			end
			default: begin
				phase_d = PH_PREFIX;
				win_d   = win_shift;
				fill_d  = fill_inc;
				if (win_full) begin
					if (len_bad) begin
						// resync: drop leading bytes until the window opens 00 00 or holds one byte
						priority if (win_shift[23:16] == BYTE_ZERO &&
						             win_shift[15:8] == BYTE_ZERO) begin
							fill_d = 3'd3;
							win_d  = {8'd0, win_shift[23:0]};
						end else if (win_shift[15:8] == BYTE_ZERO &&
						             win_shift[7:0] == BYTE_ZERO) begin
							fill_d = 3'd2;
							win_d  = {16'd0, win_shift[15:0]};
						end else begin
							fill_d = 3'd1;
							win_d  = {24'd0, win_shift[7:0]};
						end
					end else begin
						cur_len_d = win_shift;
						remain_d  = win_shift;
						fill_d    = 3'd0;
						win_d     = 32'd0;
						phase_d   = PH_PAYLOAD;
					end
				end
			end
		endcase
	end

	// result of the held word
	always_comb begin
		res_valid = 1'b0;
		res       = '{event_res: EV_PAYLOAD, payload_byte: 8'd0,
		              last_of_frame: 1'b0, frame_length: 32'd0};
		unique case (phase_q)
			PH_HEADER: begin
				if (hdr_end) begin
					res_valid     = 1'b1;
					res.event_res = EV_HDR_END;
				end
			end
			PH_PAYLOAD: begin
				res_valid         = 1'b1;
				res.payload_byte  = data_s1;
				res.last_of_frame = pay_last;
				res.frame_length  = cur_len_q;
			end
			default: begin
				if (win_full && len_bad) begin
					res_valid        = 1'b1;
					res.event_res    = EV_BAD_LEN;
					res.frame_length = win_shift;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HEADER;
			hmatch_q  <= 2'd0;
			win_q     <= 32'd0;
			fill_q    <= 3'd0;
			remain_q  <= 32'd0;
			cur_len_q <= 32'd0;
		end else if (ctl.valid && ctl.advance) begin
			phase_q   <= phase_d;
			hmatch_q  <= hmatch_d;
			win_q     <= win_d;
			fill_q    <= fill_d;
			remain_q  <= remain_d;
			cur_len_q <= cur_len_d;
		end
	end

`ifndef SYNTHESIS
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= WIN_BYTES)
		else $error("prefix window fill above four");

	a_payload_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> remain_q != 32'd0)
		else $error("payload phase with no bytes remaining");

	a_hdr_only_in_header: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.valid && ctl.advance && res_valid && res.event_res == EV_HDR_END
		|=> phase_q == PH_PREFIX && fill_q == 3'd0)
		else $error("header end did not start prefix gathering");
`endif

endmodule

// ===== rtl/lpfd_out_reg.sv =====
// ----------------------------------------------------------------------------
// lpfd_out_reg
// Result register: holds one result word until the sink takes it.
// ----------------------------------------------------------------------------
module lpfd_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  logic              res_valid,
	input  lpfd_pkg::result_t res,
	output logic              free,
	output logic              out_valid,
	input  logic              out_stall,
	output lpfd_pkg::result_t res_s2
);
	import lpfd_pkg::*;

	// free when empty or the held word leaves this cycle
	assign free = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (free) begin
			out_valid <= advance && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (free && advance && res_valid) begin
			res_s2 <= res;
		end
	end

endmodule

// ===== rtl/length_prefixed_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// length_prefixed_frame_deframer
// Strips an HTTP response header, then splits a byte stream into frames that
// each carry a 4-byte big-endian length prefix.
// ----------------------------------------------------------------------------
// One stream byte enters per word on the input channel. Bytes up to and
// including the first CR LF CR LF are dropped; the final LF gives a header-end
// result (event 2). After that, four bytes are gathered as a big-endian length.
// A length of zero or above max_frame_len gives an invalid-length result
// (event 1, frame_length holds the rejected value) and the window resyncs by
// dropping leading bytes until it opens with 00 00 or holds one byte. A good
// length gives no result; the next that-many bytes each come out as event 0
// with frame_length set and last_of_frame on the final one, and gathering
// starts over. Each byte gives at most one result word. The block takes one
// byte per clock: a byte sits in an input register, the deframer state and
// the result are worked out from it by combinational logic, and the result
// lands in an output register. A byte can enter every cycle as long as the
// output register is empty or being drained; a stall on the output holds the
// byte in the input register and stalls the input in that same cycle.
// Write max_frame_len (reset 524284) only while the block is idle; cfg_ready
// is always high.
// ----------------------------------------------------------------------------
module length_prefixed_frame_deframer (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,
	// byte input
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data,
	// result output
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  event_res,
	output logic [7:0]  payload_byte,
	output logic        last_of_frame,
	output logic [31:0] frame_length
);
	import lpfd_pkg::*;

	logic        cfg_wr;
	logic [31:0] max_frame_len_q;
	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        out_free;
	logic        advance;
	stage_ctl_t  core_ctl;
	logic        res_valid;
	result_t     res;
	result_t     res_s2;

	// take configuration at any time; the user writes only while idle
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_frame_len_q <= MAX_FRAME_LEN_RST;
		end else if (cfg_wr) begin
			max_frame_len_q <= cfg_data;
		end
	end

	// move the held byte on whenever the result register can take its word
	assign advance        = valid_s1 && out_free;
	assign core_ctl.valid = valid_s1;
	assign core_ctl.advance = advance;

	lpfd_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.data     (data),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1)
	);

	lpfd_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.data_s1       (data_s1),
		.ctl           (core_ctl),
		.max_frame_len (max_frame_len_q),
		.res_valid     (res_valid),
		.res           (res)
	);

	lpfd_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.res_valid (res_valid),
		.res       (res),
		.free      (out_free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res_s2    (res_s2)
	);

	// drive the result fields straight from the output register
	assign event_res     = res_s2.event_res;
	assign payload_byte  = res_s2.payload_byte;
	assign last_of_frame = res_s2.last_of_frame;
	assign frame_length  = res_s2.frame_length;

`ifndef SYNTHESIS
	a_non_payload_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res != EV_PAYLOAD |-> payload_byte == 8'd0 && !last_of_frame)
		else $error("non-payload result carries payload bits");

	a_hdr_len_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res == EV_HDR_END |-> frame_length == 32'd0)
		else $error("header end result with nonzero length");

	a_stall_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid && out_stall |-> in_stall)
		else $error("input taken while a byte is blocked");
`endif

endmodule
